// ===== hw/rtl/bsps_pkg.sv =====
// ============================================================================
// bsps_pkg - shared definitions for the bus serial port slave
// Phase type, item kinds, register indexes and status word layout.
// ============================================================================
package bsps_pkg;

    // Bus phase machine
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PASSING = 3'd1,
        PH_WAIT    = 3'd2,
        PH_ACTIVE  = 3'd3,
        PH_CLEANUP = 3'd4
    } t_phase;

    // Item kinds carried in tuser
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_BUS_CYCLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RX_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LINE_TAKE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IO_ADDRESS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_CYCLES = 1'd1;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 10;

    // Input tdata layout, lowest bit first
    localparam int IN_DATA_W = 56;
    localparam int IN_RD_LSB    = 0;
    localparam int IN_WR_LSB    = 1;
    localparam int IN_ADDR_LSB  = 2;
    localparam int IN_WBYTE_LSB = IN_ADDR_LSB + ADDR_W;
    localparam int IN_LBYTE_LSB = IN_WBYTE_LSB + BYTE_W;

    // Output tdata layout, lowest bit first
    localparam int OUT_DATA_W = 24;

    // Result item
    typedef struct packed {
        logic              send_valid;
        logic [BYTE_W-1:0] send_byte;
        logic              irq_level;
        logic              bus_drive;
        logic [STATUS_W-1:0] bus_data;
    } t_result;

endpackage

// ===== hw/rtl/bus_serial_port_slave_core.sv =====
// ============================================================================
// bus_serial_port_slave_core - single-byte serial port on a bus
// Bus cycle, received byte and line take items in; one status item out each.
// ============================================================================
// Every accepted item yields exactly one result item when the output side
// is ready: the item is captured in an input register, then the whole step
// (drive half, interrupt update, phase machine, tx/rx holding registers) is
// evaluated combinationally and stored in the result register. One item per
// cycle is sustained while the output side is ready; the rate is set by the
// update of the port state, which each item reads as left by the previous
// one. The input stays open while a result waits, as long as the input
// register is free or moving on. Configuration writes (io address, wait
// cycles) are always taken and must only be issued while the port is idle.
// ============================================================================
module bus_serial_port_slave_core
    import bsps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: read_enable[0], write_enable[1], bus_address[33:2],
    //        write_byte[41:34], line_byte[49:42], zero fill [55:50]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // result item channel
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: bus_data[9:0], bus_drive[10], irq_level[11], send_byte[19:12],
    //        send_valid[20], zero fill [23:21]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] r_io_address;
    logic [BYTE_W-1:0] r_wait_cycles;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_io_address  <= '0;
            r_wait_cycles <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IO_ADDRESS:  r_io_address  <= i_cfg_data;
                CFG_WAIT_CYCLES: r_wait_cycles <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                 r_in_vld;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_rd;
    logic                 r_wr;
    logic [ADDR_W-1:0]    r_addr;
    logic [BYTE_W-1:0]    r_wbyte;
    logic [BYTE_W-1:0]    r_lbyte;

    logic r_out_vld;
    logic w_advance;   // input register item moves into the result register

    assign w_advance       = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_kind  <= i_s_axis_tuser;
            r_rd    <= i_s_axis_tdata[IN_RD_LSB];
            r_wr    <= i_s_axis_tdata[IN_WR_LSB];
            r_addr  <= i_s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
            r_wbyte <= i_s_axis_tdata[IN_WBYTE_LSB +: BYTE_W];
            r_lbyte <= i_s_axis_tdata[IN_LBYTE_LSB +: BYTE_W];
        end
    end

    // ------------------------------------------------------------------
    // Port state
    // ------------------------------------------------------------------
    t_phase            r_phase,   n_phase;
    logic [BYTE_W-1:0] r_wait_count, n_wait_count;
    logic              r_write_latched, n_write_latched;
    logic [BYTE_W-1:0] r_rx_holding, n_rx_holding;
    logic              r_rx_full, n_rx_full;
    logic [BYTE_W-1:0] r_tx_holding, n_tx_holding;
    logic              r_tx_pending, n_tx_pending;
    logic              r_tx_pending_before, n_tx_pending_before;
    logic              r_irq, n_irq;
    t_result           n_result;
    t_result           r_result;

    logic w_bus_cycle;
    assign w_bus_cycle = (r_kind == KIND_BUS_CYCLE);

    // Phase machine: next state (bus cycles only)
    always_comb begin
        n_phase = r_phase;
        if (w_bus_cycle) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (r_wait_count == '0) n_phase = PH_ACTIVE;
                end
                PH_ACTIVE, PH_PASSING: begin
                    if (!r_rd) n_phase = PH_CLEANUP;
                end
                PH_CLEANUP: n_phase = PH_IDLE;
                default: begin
                    if (!r_rd) begin
                        n_phase = PH_IDLE;
                    end else if (r_addr == r_io_address) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_PASSING;
                    end
                end
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        logic w_drive;
        logic w_rx_full_mid;
        w_drive             = 1'b0;
        w_rx_full_mid       = r_rx_full;
        n_wait_count        = r_wait_count;
        n_write_latched     = r_write_latched;
        n_rx_holding        = r_rx_holding;
        n_rx_full           = r_rx_full;
        n_tx_holding        = r_tx_holding;
        n_tx_pending        = r_tx_pending;
        n_tx_pending_before = r_tx_pending_before;
        n_irq               = r_irq;
        n_result            = '0;

        unique case (r_kind)
            KIND_BUS_CYCLE: begin
                // drive half
                w_drive = (r_phase == PH_ACTIVE) && !r_write_latched;
                if (w_drive) begin
                    n_result.bus_data  = {r_tx_pending, r_rx_full,
                                          r_rx_full ? r_rx_holding : {BYTE_W{1'b0}}};
                    n_result.bus_drive = 1'b1;
                    n_irq              = 1'b0;
                    w_rx_full_mid      = 1'b0;
                end
                if (w_rx_full_mid || (r_tx_pending_before && !r_tx_pending)) begin
                    n_irq = 1'b1;
                end
                n_rx_full           = w_rx_full_mid;
                n_tx_pending_before = r_tx_pending;

                // sample half
                unique case (r_phase)
                    PH_WAIT: begin
                        if (r_wait_count == '0) begin
                            n_write_latched = r_wr;
                        end else begin
                            n_wait_count = r_wait_count - BYTE_W'(1);
                        end
                    end
                    PH_ACTIVE: begin
                        if (r_write_latched) begin
                            n_tx_holding        = r_wbyte;
                            n_tx_pending        = 1'b1;
                            n_tx_pending_before = 1'b1;
                        end
                    end
                    PH_PASSING, PH_CLEANUP: ;
                    default: begin
                        if (r_rd && (r_addr == r_io_address)) begin
                            n_wait_count = r_wait_cycles;
                        end
                    end
                endcase
            end
            KIND_RX_BYTE: begin
                n_rx_holding = r_lbyte;
                n_rx_full    = 1'b1;
            end
            KIND_LINE_TAKE: begin
                if (r_tx_pending) begin
                    n_result.send_byte  = r_tx_holding;
                    n_result.send_valid = 1'b1;
                    n_tx_pending        = 1'b0;
                end
            end
            default: ;  // unused kind leaves the port untouched
        endcase

        n_result.irq_level = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase             <= PH_IDLE;
            r_wait_count        <= '0;
            r_write_latched     <= 1'b0;
            r_rx_holding        <= '0;
            r_rx_full           <= 1'b0;
            r_tx_holding        <= '0;
            r_tx_pending        <= 1'b0;
            r_tx_pending_before <= 1'b0;
            r_irq               <= 1'b0;
        end else if (w_advance) begin
            r_phase             <= n_phase;
            r_wait_count        <= n_wait_count;
            r_write_latched     <= n_write_latched;
            r_rx_holding        <= n_rx_holding;
            r_rx_full           <= n_rx_full;
            r_tx_holding        <= n_tx_holding;
            r_tx_pending        <= n_tx_pending;
            r_tx_pending_before <= n_tx_pending_before;
            r_irq               <= n_irq;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_result};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // a result never both drives the bus and hands a byte to the line
    a_drive_xor_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_result.bus_drive && r_result.send_valid))
        else $error("bus drive and send valid in one result");

    // tx pending only clears through a line take
    a_tx_clear_by_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_tx_pending) |-> $past(w_advance && (r_kind == KIND_LINE_TAKE)))
        else $error("tx pending cleared without a line take");

    // rx full only sets through a received byte
    a_rx_set_by_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rx_full) |-> $past(w_advance && (r_kind == KIND_RX_BYTE)))
        else $error("rx full set without a received byte");

    // cleanup always returns to idle after one bus cycle
    a_cleanup_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_bus_cycle && (r_phase == PH_CLEANUP)) |=> (r_phase == PH_IDLE))
        else $error("cleanup did not return to idle");

    // full input register behind a stalled result blocks the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline is full");
`endif

endmodule

// ===== tb/bsps_port_checker.sv =====
// ============================================================================
// bsps_port_checker - result predictor and checker for the serial port core
// Watches the item, result and configuration channels, runs its own copy of
// the port state per accepted item and compares each result in order.
// ============================================================================
module bsps_port_checker
    import bsps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [KIND_W-1:0]     i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ADDR_W-1:0]     i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked
);

    // register copies
    logic [ADDR_W-1:0] port_addr;
    logic [BYTE_W-1:0] port_wait;

    // port state copy
    t_phase            phase;
    logic [BYTE_W-1:0] wait_left;
    logic              wr_latched;
    logic [BYTE_W-1:0] rx_hold;
    logic              rx_full;
    logic [BYTE_W-1:0] tx_hold;
    logic              tx_pend;
    logic              tx_pend_prev;
    logic              irq;

    t_result status_due[$];
    int      fails   = 0;
    int      checked = 0;

    function automatic void clear_port();
        port_addr    = '0;
        port_wait    = '0;
        phase        = PH_IDLE;
        wait_left    = '0;
        wr_latched   = 1'b0;
        rx_hold      = '0;
        rx_full      = 1'b0;
        tx_hold      = '0;
        tx_pend      = 1'b0;
        tx_pend_prev = 1'b0;
        irq          = 1'b0;
    endfunction

    // one item through the port: drive half, irq update, then sample half
    function automatic t_result port_step(input logic [KIND_W-1:0] kind,
                                          input logic [IN_DATA_W-1:0] d);
        t_result           r;
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wbyte;
        logic [BYTE_W-1:0] lbyte;
        r     = '0;
        rd    = d[IN_RD_LSB];
        wr    = d[IN_WR_LSB];
        addr  = d[IN_ADDR_LSB +: ADDR_W];
        wbyte = d[IN_WBYTE_LSB +: BYTE_W];
        lbyte = d[IN_LBYTE_LSB +: BYTE_W];
        case (kind)
            KIND_BUS_CYCLE: begin
                if (phase == PH_ACTIVE && !wr_latched) begin
                    r.bus_data  = {tx_pend, rx_full, rx_full ? rx_hold : 8'h00};
                    r.bus_drive = 1'b1;
                    irq         = 1'b0;
                    rx_full     = 1'b0;
                end
                if (rx_full || (tx_pend_prev && !tx_pend))
                    irq = 1'b1;
                tx_pend_prev = tx_pend;
                case (phase)
                    PH_WAIT: begin
                        if (wait_left == 0) begin
                            phase      = PH_ACTIVE;
                            wr_latched = wr;
                        end else begin
                            wait_left = wait_left - 8'd1;
                        end
                    end
                    PH_ACTIVE: begin
                        if (wr_latched) begin
                            tx_hold      = wbyte;
                            tx_pend      = 1'b1;
                            tx_pend_prev = 1'b1;
                        end
                        if (!rd)
                            phase = PH_CLEANUP;
                    end
                    PH_PASSING: begin
                        if (!rd)
                            phase = PH_CLEANUP;
                    end
                    PH_CLEANUP: phase = PH_IDLE;
                    default: begin
                        if (!rd) begin
                            phase = PH_IDLE;
                        end else if (addr == port_addr) begin
                            phase     = PH_WAIT;
                            wait_left = port_wait;
                        end else begin
                            phase = PH_PASSING;
                        end
                    end
                endcase
            end
            KIND_RX_BYTE: begin
                rx_hold = lbyte;
                rx_full = 1'b1;
            end
            KIND_LINE_TAKE: begin
                if (tx_pend) begin
                    r.send_byte  = tx_hold;
                    r.send_valid = 1'b1;
                    tx_pend      = 1'b0;
                end
            end
            default: ;
        endcase
        r.irq_level = irq;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        fails++;
        if (fails <= 10)
            $display("mismatch %0d (%s): expected data=%h drive=%b irq=%b send=%h/%b",
                     fails, what, want.bus_data, want.bus_drive, want.irq_level,
                     want.send_byte, want.send_valid,
                     "; got data=%h drive=%b irq=%b send=%h/%b",
                     got.bus_data, got.bus_drive, got.irq_level,
                     got.send_byte, got.send_valid);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_port();
            status_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(t_result)-1:0];
                if (status_due.size() == 0) begin
                    note_mismatch("unexpected item", '0, got);
                end else begin
                    want = status_due.pop_front();
                    checked++;
                    if (got.bus_data !== want.bus_data || got.bus_drive !== want.bus_drive
                            || got.irq_level !== want.irq_level
                            || got.send_byte !== want.send_byte
                            || got.send_valid !== want.send_valid)
                        note_mismatch("field", want, got);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IO_ADDRESS:  port_addr = i_cfg_data;
                    CFG_WAIT_CYCLES: port_wait = i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                status_due.push_back(port_step(i_s_tuser, i_s_tdata));
        end
        o_pending    <= status_due.size();
        o_mismatches <= fails;
        o_checked    <= checked;
    end

endmodule

// ===== tb/bus_serial_port_slave_core_tb.sv =====
// ============================================================================
// bus_serial_port_slave_core_tb - stimulus and verdict for the serial port
// Directed bus, line and receive items, then random bus transactions with
// side items, over several register settings; a checker predicts results.
// ============================================================================
module bus_serial_port_slave_core_tb;
    import bsps_pkg::*;

    // tuser code the port does not use; must change nothing
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int IDLE_PCT    = 24;     // chance per cycle that a side idles
    localparam int HOLD_CYCLES = 300;    // long output hold-off
    localparam int DRAIN_TAIL  = 10;     // cycles after the last result

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data  = '0;

    int mismatches;
    int pending;
    int checked;

    // shared between the sender and the receiver
    bit steady   = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // ask the receiver for a long hold-off
    int items_sent    = 0;
    int settings_used = 0;

    bus_serial_port_slave_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bsps_port_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // run limit, far beyond the slowest legal run
    initial begin
        #400000;
        $display("bus_serial_port_slave_core_tb: errors");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering items and the
    // core has to fill up and drop its input ready.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready  <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // One item on the input channel. Valid stays high from one item to the
    // next; it only drops in idle gaps or in settle().
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic rd, input logic wr,
                             input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] wbyte,
                             input logic [BYTE_W-1:0] lbyte);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_RD_LSB]               = rd;
        d[IN_WR_LSB]               = wr;
        d[IN_ADDR_LSB +: ADDR_W]   = addr;
        d[IN_WBYTE_LSB +: BYTE_W]  = wbyte;
        d[IN_LBYTE_LSB +: BYTE_W]  = lbyte;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic bus_cycle(input logic rd, input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] wbyte);
        send_item(KIND_BUS_CYCLE, rd, wr, addr, wbyte, BYTE_W'($urandom_range(255)));
    endtask

    // line events dropped between bus cycles: mostly received bytes and takes
    task automatic side_item();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            send_item(KIND_RX_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                      BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        else if (pick < 9)
            send_item(KIND_LINE_TAKE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                      BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
        else
            send_item(KIND_SPARE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                      BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
    endtask

    // Read enable held for rd_cycles bus cycles (address, wait phase, active
    // phase), then low for the bus cycles that pass through cleanup back to idle.
    task automatic bus_transaction(input logic wr, input logic [ADDR_W-1:0] addr,
                                   input int rd_cycles, input logic [BYTE_W-1:0] wbyte,
                                   input int side_pct);
        int i;
        for (i = 0; i < rd_cycles + 2; i++) begin
            bus_cycle(i < rd_cycles, wr, addr, wbyte);
            if ($urandom_range(99) < side_pct)
                side_item();
        end
    endtask

    // stop offering items and wait for every expected result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly well-formed transactions at the port address (some broken off
    // early, some to other addresses); the rest is loose noise.
    task automatic random_sequence(input logic [ADDR_W-1:0] port_addr,
                                   input logic [BYTE_W-1:0] port_wait);
        int                roll;
        int                n;
        logic [ADDR_W-1:0] addr;
        roll = $urandom_range(99);
        if (roll < 15) begin
            addr = $urandom_range(1) ? port_addr : ADDR_W'($urandom);
            send_item(KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), addr, BYTE_W'($urandom_range(255)),
                      BYTE_W'($urandom_range(255)));
        end else if (roll < 22) begin
            bus_cycle(1'b0, 1'($urandom_range(1)), $urandom, BYTE_W'($urandom_range(255)));
        end else begin
            addr = ($urandom_range(9) != 0) ? port_addr : ADDR_W'($urandom);
            n = int'(port_wait) + 2 + $urandom_range(3);
            if ($urandom_range(9) == 0)
                n = $urandom_range(n, 1);
            bus_transaction(1'($urandom_range(1)), addr, n, BYTE_W'($urandom_range(255)), 20);
        end
    endtask

    initial begin
        int                set_i;
        int                budget;
        int                start;
        bit                paused;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wcyc;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults written explicitly: port at address 0, no wait cycles
        write_reg(CFG_IO_ADDRESS, '0);
        write_reg(CFG_WAIT_CYCLES, '0);
        settings_used++;

        // -- directed --
        send_item(KIND_SPARE, 1'b1, 1'b1, '1, 8'hFF, 8'hFF);  // unused kind
        send_item(KIND_LINE_TAKE, 1'b0, 1'b0, '0, 8'h00, 8'h00);  // nothing pending
        send_item(KIND_RX_BYTE, 1'b0, 1'b0, '0, 8'h00, 8'hFF);  // irq waits for bus
        bus_cycle(1'b0, 1'b0, '0, 8'h00);                        // irq from rx full
        bus_transaction(1'b0, '0, 3, 8'h00, 0);  // read, two driven cycles
        bus_transaction(1'b1, '0, 2, 8'hFF, 0);  // write latches 0xff
        bus_transaction(1'b0, '0, 2, 8'h00, 0);  // read sees tx pending
        send_item(KIND_LINE_TAKE, 1'b0, 1'b0, '0, 8'h00, 8'h00);  // line takes 0xff
        bus_cycle(1'b0, 1'b0, '0, 8'h00);                        // irq on tx drain
        bus_transaction(1'b0, '1, 2, 8'h00, 0);  // other address: passing
        send_item(KIND_RX_BYTE, 1'b0, 1'b0, '0, 8'h00, 8'h00);

        // -- random, one block per register setting --
        for (set_i = 0; set_i < 5; set_i++) begin
            case (set_i)
                0: begin addr = $urandom;     wcyc = 8'd0;   budget = 200; end
                1: begin addr = '1;           wcyc = 8'hFF;  budget = 550; end
                2: begin addr = $urandom;     wcyc = 8'd3;   budget = 200; end
                3: begin addr = '0;           wcyc = 8'd1;   budget = 150; end
                default: begin
                    addr = $urandom;
                    wcyc = BYTE_W'($urandom_range(7));
                    budget = 200;
                end
            endcase
            settle();
            write_reg(CFG_IO_ADDRESS, addr);
            write_reg(CFG_WAIT_CYCLES, ADDR_W'(wcyc));
            settings_used++;
            steady = (set_i == 3);
            if (set_i == 2)
                hold_req = 1'b1;
            paused = 1'b0;
            start  = items_sent;
            while (items_sent - start < budget) begin
                // one full drain in the middle of a block
                if (set_i == 2 && !paused && items_sent - start >= budget / 2) begin
                    settle();
                    paused = 1'b1;
                end
                random_sequence(addr, wcyc);
            end
        end
        steady = 1'b0;

        settle();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("run covered %0d items under %0d register settings, %0d results checked",
                 items_sent, settings_used, checked);
        $display("with a long output hold-off, a mid-run drain and an idle-free block");
        if (mismatches == 0 && pending == 0)
            $display("bus_serial_port_slave_core_tb: clean");
        else
            $display("bus_serial_port_slave_core_tb: errors");
        $finish;
    end

endmodule
